>>> sv/pidc_pkg.sv
// ----------------------------------------------------------------------------
// pidc_pkg
// widths, register codes and shared types of the positional pid controller
// ----------------------------------------------------------------------------
package pidc_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int GAIN_W    = 16;
    localparam int GAIN_FRAC = 8;
    localparam int SUM_W     = 32;
    localparam int OUT_W     = 32;
    localparam int MODE_W    = 2;

    // error and error difference
    localparam int ERR_W  = SAMPLE_W + 1;
    localparam int DERR_W = ERR_W + 1;

    // products and accumulator
    localparam int PP_W  = GAIN_W + ERR_W;
    localparam int PI_W  = GAIN_W + SUM_W;
    localparam int PD_W  = GAIN_W + DERR_W;
    localparam int ACC_W = PI_W + 2;

    // configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_W      = 16;

    localparam logic [CFG_ADDR_W-1:0] REG_TARGET = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_GAIN_P = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_GAIN_I = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_GAIN_D = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_MODE   = 3'd4;

    localparam logic [MODE_W-1:0] MODE_P   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_PI  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PID = 2'd2;

    // job queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] target;
        logic signed [GAIN_W-1:0]   gain_p;
        logic signed [GAIN_W-1:0]   gain_i;
        logic signed [GAIN_W-1:0]   gain_d;
        logic        [MODE_W-1:0]   mode;
    } t_cfg;

    // operands for the three products, unused terms already zeroed
    typedef struct packed {
        logic signed [ERR_W-1:0]  err;
        logic signed [SUM_W-1:0]  sum;
        logic signed [DERR_W-1:0] derr;
    } t_job;

endpackage

>>> sv/positional_pid_controller.sv
// ----------------------------------------------------------------------------
// positional_pid_controller
// discrete positional pid controller, one measured sample in, one drive out
// ----------------------------------------------------------------------------
// Each accepted sample gives one drive value: err = target - sample, and
// drive = sat32((kp*err + ki*sum + kd*(err - last_err)) >>> 8), gains in
// signed q8.8 and the shift rounding toward minus infinity. In pi and pid
// modes the error is first added into a saturating 32-bit integral; the last
// error is kept only in pid mode (mode code three behaves as pid). The block
// takes one item per clock unless the queue is full, limited by the
// saturating integral update in the front; a drive value passes the queue,
// then the product, sum and output registers. A two-entry queue separates
// the front from the three-stage multiply, sum and saturate back, so the
// input keeps flowing while a result waits to be taken. Registers are
// written through i_cfg_we/i_cfg_addr/i_cfg_data; the user must write them
// only while the block is idle, which the block does not enforce. The order
// is target, gain_p, gain_i, gain_d, loop_mode; other indexes ignore writes.
// ----------------------------------------------------------------------------
module positional_pid_controller
    import pidc_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // configuration writes
    input  logic                         i_cfg_we,
    input  logic [CFG_ADDR_W-1:0]        i_cfg_addr,
    input  logic [CFG_W-1:0]             i_cfg_data,
    // sample channel
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic signed [SAMPLE_W-1:0]   i_measured_value,
    // drive channel
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic signed [OUT_W-1:0]      o_drive_value
);

    // configuration registers
    t_cfg r_cfg, n_cfg;

    // front to queue
    logic push;
    t_job push_job;
    logic q_full;

    // queue to back
    logic q_valid;
    logic q_pop;
    t_job pop_job;

    // register decode, mode reset is full pid
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_TARGET: n_cfg.target = i_cfg_data[SAMPLE_W-1:0];
                REG_GAIN_P: n_cfg.gain_p = i_cfg_data[GAIN_W-1:0];
                REG_GAIN_I: n_cfg.gain_i = i_cfg_data[GAIN_W-1:0];
                REG_GAIN_D: n_cfg.gain_d = i_cfg_data[GAIN_W-1:0];
                REG_MODE:   n_cfg.mode   = i_cfg_data[MODE_W-1:0];
                default:    n_cfg        = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target <= '0;
            r_cfg.gain_p <= '0;
            r_cfg.gain_i <= '0;
            r_cfg.gain_d <= '0;
            r_cfg.mode   <= MODE_PID;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // front: error, integral and last error, zeroes unused terms
    pidc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_valid  (i_in_valid),
        .o_ready  (o_in_ready),
        .i_sample (i_measured_value),
        .o_push   (push),
        .o_job    (push_job),
        .i_q_full (q_full)
    );

    // decoupling queue
    pidc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_job   (pop_job)
    );

    // back: gains, sum, scale and clamp
    pidc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (q_valid),
        .o_q_pop   (q_pop),
        .i_job     (pop_job),
        .o_valid   (o_out_valid),
        .i_ready   (i_out_ready),
        .o_drive   (o_drive_value)
    );

    // a sample accepted with the queue full would be lost
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !q_full)
        else $error("item pushed into a full queue");

    // the mode must not be written while items wait in the queue
    a_cfg_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_we && i_cfg_addr == REG_MODE) |-> !q_valid)
        else $error("mode written with items queued");

    a_mode_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_cfg.mode == MODE_PID))
        else $error("mode not full pid after reset");

endmodule

>>> sv/pidc_front.sv
// ----------------------------------------------------------------------------
// pidc_front
// takes samples, forms the error and keeps the integral and last error
// ----------------------------------------------------------------------------
module pidc_front
    import pidc_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_cfg                       i_cfg,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    output logic                       o_push,
    output t_job                       o_job,
    input  logic                       i_q_full
);

    logic signed [SUM_W-1:0]  r_error_sum, n_error_sum;
    logic signed [ERR_W-1:0]  r_prev_err,  n_prev_err;
    logic signed [ERR_W-1:0]  err;
    logic signed [DERR_W-1:0] derr;
    logic signed [SUM_W:0]    sum_wide;
    logic signed [SUM_W-1:0]  sum_sat;
    logic                     accept;
    logic                     use_i;
    logic                     use_d;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && !i_q_full;
    assign use_i   = (i_cfg.mode != MODE_P);
    assign use_d   = use_i && (i_cfg.mode != MODE_PI);

    assign err  = ERR_W'(i_cfg.target) - ERR_W'(i_sample);
    assign derr = DERR_W'(err) - DERR_W'(r_prev_err);

    // saturating integral update
    assign sum_wide = (SUM_W+1)'(r_error_sum) + (SUM_W+1)'(err);
    always_comb begin
        if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
            sum_sat = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                      : {1'b0, {(SUM_W-1){1'b1}}};
        end else begin
            sum_sat = sum_wide[SUM_W-1:0];
        end
    end

    always_comb begin
        n_error_sum = r_error_sum;
        n_prev_err  = r_prev_err;
        if (accept && use_i) begin
            n_error_sum = sum_sat;
        end
        if (accept && use_d) begin
            n_prev_err = err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_error_sum <= '0;
            r_prev_err  <= '0;
        end else begin
            r_error_sum <= n_error_sum;
            r_prev_err  <= n_prev_err;
        end
    end

    assign o_push     = accept;
    assign o_job.err  = err;
    assign o_job.sum  = use_i ? sum_sat : '0;
    assign o_job.derr = use_d ? derr : '0;

    a_p_mode_keeps_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_cfg.mode == MODE_P) |=> ($stable(r_error_sum) && $stable(r_prev_err)))
        else $error("proportional step changed controller state");

    a_pi_mode_keeps_prev: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_cfg.mode == MODE_PI) |=> $stable(r_prev_err))
        else $error("pi step changed last error");

    a_idle_keeps_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !accept |=> ($stable(r_error_sum) && $stable(r_prev_err)))
        else $error("state changed without an accepted item");

endmodule

>>> sv/pidc_queue.sv
// ----------------------------------------------------------------------------
// pidc_queue
// short job queue between front and back
// ----------------------------------------------------------------------------
module pidc_queue
    import pidc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    output logic o_valid,
    input  logic i_pop,
    output t_job o_job
);

    t_job              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_count,  n_count;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_count == QCNT_W'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QDEPTH))
        else $error("queue count past depth");

    a_push_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_push && !do_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count missed a push");

endmodule

>>> sv/pidc_back.sv
// ----------------------------------------------------------------------------
// pidc_back
// products, sum, scaling and output saturation in three stages
// ----------------------------------------------------------------------------
module pidc_back
    import pidc_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cfg                    i_cfg,
    input  logic                    i_q_valid,
    output logic                    o_q_pop,
    input  t_job                    i_job,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic signed [OUT_W-1:0] o_drive
);

    logic                    r_v1, r_v2, r_v3;
    logic signed [PP_W-1:0]  r_pp;
    logic signed [PI_W-1:0]  r_pi;
    logic signed [PD_W-1:0]  r_pd;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [OUT_W-1:0] r_drive;
    logic signed [ACC_W-1:0] n_acc;
    logic signed [ACC_W-1:0] scaled;
    logic signed [OUT_W-1:0] drive_sat;
    logic                    en1, en2, en3;
    logic                    ovf;

    // a stage moves when the one after it is empty or moving
    assign en3     = !r_v3 || i_ready;
    assign en2     = !r_v2 || en3;
    assign en1     = !r_v1 || en2;
    assign o_q_pop = i_q_valid && en1;

    assign n_acc  = ACC_W'(r_pp) + ACC_W'(r_pi) + ACC_W'(r_pd);
    assign scaled = r_acc >>> GAIN_FRAC;
    assign ovf    = !((&scaled[ACC_W-1:OUT_W-1]) || !(|scaled[ACC_W-1:OUT_W-1]));

    always_comb begin
        if (ovf) begin
            drive_sat = scaled[ACC_W-1] ? {1'b1, {(OUT_W-1){1'b0}}}
                                        : {1'b0, {(OUT_W-1){1'b1}}};
        end else begin
            drive_sat = scaled[OUT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= i_q_valid;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_pp <= i_cfg.gain_p * i_job.err;
            r_pi <= i_cfg.gain_i * i_job.sum;
            r_pd <= i_cfg.gain_d * i_job.derr;
        end
        if (en2) begin
            r_acc <= n_acc;
        end
        if (en3) begin
            r_drive <= drive_sat;
        end
    end

    assign o_valid = r_v3;
    assign o_drive = r_drive;

    a_stage_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && en3) |=> r_v3)
        else $error("item lost between sum and output stage");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && r_v2 && !i_ready) |=> r_v2)
        else $error("sum stage dropped an item during a stall");

endmodule

>>> tb/sv/positional_pid_controller_test.sv
// ----------------------------------------------------------------------------
// positional_pid_controller_test
// self-checking bench for the positional pid controller
// ----------------------------------------------------------------------------
// A scoreboard keeps its own copy of the gains, the setpoint, the loop mode,
// the integral and the last error, and works out the drive value of every
// sample that the block accepts. Each drive item that leaves the block is
// compared with the oldest expected value. The run starts with a short
// directed set covering the sample and gain extremes, every loop mode, and
// writes to unused register indexes. It continues with random phases under
// random idle bursts on both channels, a long output stall and a full drain.
// Two sweeps then build up a large integral and drive the output toward
// saturation at both ends. A final random phase runs without idling.
// ----------------------------------------------------------------------------
module positional_pid_controller_test;
    import pidc_pkg::*;

    // mode code three, handled like full pid
    localparam logic [MODE_W-1:0] MODE_PID_ALT = 2'd3;
    localparam int DRAIN_CYCLES = 8;

    // ------------------------------------------------------------------------
    // scoreboard: predicts drive values and checks the ones that come out
    // ------------------------------------------------------------------------
    class pid_scoreboard;
        logic signed [SAMPLE_W-1:0] target;
        logic signed [GAIN_W-1:0]   kp;
        logic signed [GAIN_W-1:0]   ki;
        logic signed [GAIN_W-1:0]   kd;
        logic        [MODE_W-1:0]   mode;
        logic signed [SUM_W-1:0]    err_sum;
        logic signed [ERR_W-1:0]    last_err;
        logic signed [OUT_W-1:0]    drive_q[$];
        int                         failures;

        function new();
            target   = '0;
            kp       = '0;
            ki       = '0;
            kd       = '0;
            mode     = MODE_PID;
            err_sum  = '0;
            last_err = '0;
            failures = 0;
        endfunction

        function longint clamp32(longint v);
            if (v > longint'(32'sh7FFF_FFFF))
                return longint'(32'sh7FFF_FFFF);
            if (v < -longint'(32'sh7FFF_FFFF) - 1)
                return -longint'(32'sh7FFF_FFFF) - 1;
            return v;
        endfunction

        function void write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                REG_TARGET: target = data;
                REG_GAIN_P: kp     = data;
                REG_GAIN_I: ki     = data;
                REG_GAIN_D: kd     = data;
                REG_MODE:   mode   = data[MODE_W-1:0];
                default: ;
            endcase
        endfunction

        // one accepted sample gives exactly one drive value
        function void note_sample(logic signed [SAMPLE_W-1:0] meas);
            longint e;
            longint acc;
            longint s;
            logic signed [OUT_W-1:0] drive;
            e   = longint'(target) - longint'(meas);
            acc = longint'(kp) * e;
            if (mode != MODE_P) begin
                s       = clamp32(longint'(err_sum) + e);
                err_sum = s[SUM_W-1:0];
                acc     = acc + longint'(ki) * longint'(err_sum);
                if (mode != MODE_PI) begin
                    acc      = acc + longint'(kd) * (e - longint'(last_err));
                    last_err = e[ERR_W-1:0];
                end
            end
            // arithmetic shift of a signed value rounds toward minus infinity
            acc   = clamp32(acc >>> GAIN_FRAC);
            drive = acc[OUT_W-1:0];
            drive_q.push_back(drive);
        endfunction

        function void check_drive(logic signed [OUT_W-1:0] got);
            logic signed [OUT_W-1:0] want;
            if (drive_q.size() == 0) begin
                if (failures < 10)
                    $display("drive item %0d with no sample pending", got);
                failures++;
                return;
            end
            want = drive_q.pop_front();
            if (got !== want) begin
                if (failures < 10)
                    $display("drive mismatch: expected %0d, got %0d", want, got);
                failures++;
            end
        endfunction

        function int pending();
            return drive_q.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // clock, dut and bench state
    // ------------------------------------------------------------------------
    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_cfg_we;
    logic [CFG_ADDR_W-1:0]       i_cfg_addr;
    logic [CFG_W-1:0]            i_cfg_data;
    logic                        i_in_valid;
    logic                        o_in_ready;
    logic signed [SAMPLE_W-1:0]  i_measured_value;
    logic                        o_out_valid;
    logic                        i_out_ready;
    logic signed [OUT_W-1:0]     o_drive_value;

    pid_scoreboard sb;
    bit            idle_on;
    int            rx_hold;

    always #10 i_clk = ~i_clk;

    positional_pid_controller dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_addr       (i_cfg_addr),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_measured_value (i_measured_value),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_drive_value    (o_drive_value)
    );

    // ------------------------------------------------------------------------
    // drive channel: ready with idle bursts, plus a long hold when asked
    // ------------------------------------------------------------------------
    initial begin : drive_sink
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (rx_hold > 0) begin
                // long hold-off so the queue fills and the input stalls
                i_out_ready <= 1'b0;
                rx_hold--;
            end else if (stall_left > 0) begin
                i_out_ready <= 1'b0;
                stall_left--;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                i_out_ready <= 1'b0;
                stall_left = $urandom_range(1, 15) - 1;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // every handshake on the drive channel is checked at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_drive(o_drive_value);
    end

    // ------------------------------------------------------------------------
    // sample channel and configuration tasks, all called at a falling edge
    // ------------------------------------------------------------------------
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] meas);
        i_in_valid       <= 1'b1;
        i_measured_value <= meas;
        do
            @(posedge i_clk);
        while (!o_in_ready);
        sb.note_sample(meas);
        @(negedge i_clk);
        // random gap after the item
        if (idle_on && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge i_clk);
        end
    endtask

    // stop offering samples until every drive value has come back
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= data;
        sb.write_reg(idx, data);
        @(negedge i_clk);
    endtask

    // writes every register, then optionally the unused indexes with junk
    task automatic set_config(
        input logic [CFG_W-1:0] tgt,
        input logic [CFG_W-1:0] gp,
        input logic [CFG_W-1:0] gi,
        input logic [CFG_W-1:0] gd,
        input logic [CFG_W-1:0] mode_word,
        input bit               junk
    );
        cfg_write(REG_TARGET, tgt);
        cfg_write(REG_GAIN_P, gp);
        cfg_write(REG_GAIN_I, gi);
        cfg_write(REG_GAIN_D, gd);
        cfg_write(REG_MODE, mode_word);
        if (junk) begin
            for (int a = REG_MODE + 1; a < 2 ** CFG_ADDR_W; a++)
                cfg_write(a[CFG_ADDR_W-1:0], CFG_W'($urandom));
        end
        i_cfg_we <= 1'b0;
    endtask

    // gains and setpoint: the extremes, small values and anything at all
    function automatic logic [CFG_W-1:0] pick_reg_value();
        case ($urandom_range(0, 4))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return CFG_W'($urandom_range(0, 1024)) - 16'd512;
            default: return CFG_W'($urandom);
        endcase
    endfunction

    // samples: extremes, close to the setpoint, or anything
    function automatic logic signed [SAMPLE_W-1:0] pick_meas();
        case ($urandom_range(0, 7))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2, 3:    return sb.target + SAMPLE_W'($urandom_range(0, 64)) - 16'sd32;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // one random phase: fresh settings, then a run of samples
    task automatic random_phase(input int n, input bit hold, input bit pause);
        logic [CFG_W-1:0] mode_word;
        mode_word = CFG_W'($urandom);
        mode_word[MODE_W-1:0] = MODE_W'($urandom_range(0, 3));
        set_config(pick_reg_value(), pick_reg_value(), pick_reg_value(),
                   pick_reg_value(), mode_word, $urandom_range(0, 1));
        for (int k = 0; k < n; k++) begin
            if (hold && k == n / 3)
                rx_hold = 40 + $urandom_range(0, 40);
            if (pause && k == (2 * n) / 3)
                wait_drained();
            send_sample(pick_meas());
        end
        wait_drained();
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        i_clk            = 1'b0;
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_addr       = '0;
        i_cfg_data       = '0;
        i_in_valid       = 1'b0;
        i_measured_value = '0;
        i_out_ready      = 1'b0;
        idle_on          = 1'b1;
        rx_hold          = 0;
        sb               = new();

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings: zero gains in pid mode give zero drive
        send_sample(16'sh8000);
        send_sample(16'sh7FFF);
        wait_drained();

        // proportional only, largest positive error and zero error
        set_config(16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF, {14'h0, MODE_P}, 1'b1);
        send_sample(16'sh8000);
        send_sample(16'sh7FFF);
        send_sample(16'sh0000);
        wait_drained();

        // proportional-integral with the most negative gain
        set_config(16'h8000, 16'h8000, 16'h7FFF, 16'h8000, {14'h3FFF, MODE_PI}, 1'b1);
        send_sample(16'sh7FFF);
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);
        wait_drained();

        // full pid
        set_config(16'h0000, 16'h0100, 16'hFF00, 16'h7FFF, {14'h0, MODE_PID}, 1'b0);
        send_sample(16'sh8000);
        send_sample(16'sh7FFF);
        send_sample(16'sh0001);
        send_sample(16'shFFFF);
        wait_drained();

        // proportional again: integral and last error must stay frozen
        cfg_write(REG_MODE, {14'h0, MODE_P});
        i_cfg_we <= 1'b0;
        send_sample(16'sh1234);
        send_sample(16'sh8000);
        wait_drained();

        // mode code three behaves as pid and picks up the frozen state
        set_config(16'h7FFF, 16'h8000, 16'h8000, 16'h8000, {14'h2AAA, MODE_PID_ALT}, 1'b0);
        send_sample(16'sh8000);
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);
        send_sample(16'sh0000);
        wait_drained();

        // random phases with idle bursts; the first one always holds the
        // drive side off for a long stretch and drains mid-phase
        for (int ph = 0; ph < 5; ph++)
            random_phase(100, ph == 0 || $urandom_range(0, 2) == 0,
                         ph == 0 || $urandom_range(0, 2) == 0);

        // integral sweep up with no idling: the growing sum carries the
        // drive up to its upper limit
        idle_on = 1'b0;
        set_config(16'h7FFF, pick_reg_value(), 16'h7FFF, 16'h0000, {14'h0, MODE_PI}, 1'b0);
        for (int k = 0; k < 400; k++)
            send_sample(16'sh8000);
        wait_drained();

        // sweep down in pid mode with a negative integral gain: the still
        // large sum holds the drive at its lower limit while it shrinks
        set_config(16'h8000, pick_reg_value(), 16'h8000, 16'h7FFF, {14'h0, MODE_PID}, 1'b0);
        for (int k = 0; k < 100; k++)
            send_sample(16'sh7FFF);
        wait_drained();

        // last stretch runs without idling on either side
        random_phase(60, 1'b0, 1'b0);

        if (sb.failures == 0 && sb.pending() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // watchdog, far beyond the slowest correct run
    initial begin
        #20000000;
        $display("Some tests failed");
        $finish;
    end

endmodule

>>> sim.f
sv/pidc_pkg.sv
sv/pidc_front.sv
sv/pidc_queue.sv
sv/pidc_back.sv
sv/positional_pid_controller.sv
tb/sv/positional_pid_controller_test.sv
